[hw/rtl/wav_stream_parser_unit_defines.svh]
// Assertion macros shared by the stream parser RTL.
`ifndef WAV_STREAM_PARSER_UNIT_DEFINES_SVH
`define WAV_STREAM_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTH
// The condition must never hold outside reset.
`define WSP_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
// The antecedent implies the consequent in the same cycle.
`define WSP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// The antecedent implies the consequent in the next cycle.
`define WSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define WSP_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`define WSP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define WSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[hw/rtl/wsp_pkg.sv]
// Constants and result type of the RIFF/WAVE stream parser.
package wsp_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_FORMAT = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NOT_RIFF    = 3'd0;
  localparam logic [2:0] ERR_NOT_WAVE    = 3'd1;
  localparam logic [2:0] ERR_FMT_SMALL   = 3'd2;
  localparam logic [2:0] ERR_WIDE_SAMPLE = 3'd3;
  localparam logic [2:0] ERR_FMT_MISSING = 3'd4;
  localparam logic [2:0] ERR_NO_DATA     = 3'd5;
  localparam logic [2:0] ERR_ZERO_FORMAT = 3'd6;
  localparam logic [2:0] ERR_TRUNCATED   = 3'd7;

  // Four-character tags, first character in the top byte.
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_MIN_LEN = 32'd16;
  localparam logic [15:0] BITS_MAX    = 16'd16;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample;
    logic [15:0]        channel_index;
    logic [31:0]        sample_rate;
    logic [15:0]        channel_count;
    logic [1:0]         bytes_per_sample;
    logic [2:0]         error_code;
  } result_t;

endpackage

[hw/rtl/wav_stream_parser_unit.sv]
// RIFF/WAVE byte-stream parser: top level with input register, parse logic and result register.
//
// Usage: the file enters one byte per beat on the input channel (in_byte_i with
// end_of_stream_i set on the last byte). Each byte gives at most one result beat on
// the output channel: format info, a sample with its channel, an error, or data
// complete. Fields that do not belong to a result kind read as zero.
// Results are registered: the parse logic sits between the input register and the
// result register. Throughput: one byte per cycle unless a result waits on a stalled
// receiver; every field update is a single shallow step.
// A stalled receiver holds the result register; the block still takes a byte
// into its input register, and further bytes wait only when that byte has a
// result to deliver. Bytes without a result never wait on the output.
// Reset clears the parse state to waiting for the RIFF tag and empties both
// registers. After the end-of-stream byte the parser rearms in the same way.
// After an error every byte is dropped until the end-of-stream byte.
`include "wav_stream_parser_unit_defines.svh"

module wav_stream_parser_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               end_of_stream_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic signed [15:0] sample_o,
  output logic [15:0]        channel_index_o,
  output logic [31:0]        sample_rate_o,
  output logic [15:0]        channel_count_o,
  output logic [1:0]         bytes_per_sample_o,
  output logic [2:0]         error_code_o
);
  import wsp_pkg::*;

  localparam logic [3:0] PH_RIFF_TAG   = 4'd0;
  localparam logic [3:0] PH_RIFF_SIZE  = 4'd1;
  localparam logic [3:0] PH_WAVE_TAG   = 4'd2;
  localparam logic [3:0] PH_CHUNK_ID   = 4'd3;
  localparam logic [3:0] PH_CHUNK_SIZE = 4'd4;
  localparam logic [3:0] PH_FMT_BODY   = 4'd5;
  localparam logic [3:0] PH_SKIP       = 4'd6;
  localparam logic [3:0] PH_DATA       = 4'd7;
  localparam logic [3:0] PH_DONE       = 4'd8;
  localparam logic [3:0] PH_ERROR      = 4'd9;

  // Input register.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_eos_q;

  // Parse state.
  logic [3:0]  phase_q, phase_d;
  logic [3:0]  fcnt_q, fcnt_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] clen_q, clen_d;
  logic [31:0] skip_q, skip_d;
  logic [31:0] drem_q, drem_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [1:0]  width_q, width_d;
  logic        fmt_seen_q, fmt_seen_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] cur_q, cur_d;

  // Result register.
  logic    out_valid_q;
  result_t out_q;

  logic        res_valid;
  result_t     res;
  logic        advance;
  logic [16:0] frame_bytes;
  logic [31:0] tag_next;
  logic [31:0] clen_new;
  logic [15:0] bits;
  logic [16:0] cur_inc;
  logic        complete;

  always_comb begin
    case (width_q)
      2'd1:    frame_bytes = {1'b0, chan_q};
      2'd2:    frame_bytes = {chan_q, 1'b0};
      default: frame_bytes = '0;
    endcase
  end

  assign tag_next = {tag_q[23:0], s1_byte_q};
  assign bits     = {s1_byte_q, low_q};
  assign cur_inc  = {1'b0, cur_q} + 17'd1;

  always_comb begin
    clen_new = clen_q;
    case (fcnt_q[1:0])
      2'd0:    clen_new[7:0]   = clen_q[7:0]   | s1_byte_q;
      2'd1:    clen_new[15:8]  = clen_q[15:8]  | s1_byte_q;
      2'd2:    clen_new[23:16] = clen_q[23:16] | s1_byte_q;
      default: clen_new[31:24] = clen_q[31:24] | s1_byte_q;
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    fcnt_d     = fcnt_q;
    tag_d      = tag_q;
    clen_d     = clen_q;
    skip_d     = skip_q;
    drem_d     = drem_q;
    chan_d     = chan_q;
    rate_d     = rate_q;
    width_d    = width_q;
    fmt_seen_d = fmt_seen_q;
    low_d      = low_q;
    cur_d      = cur_q;
    res_valid  = 1'b0;
    res        = '0;
    complete   = 1'b0;

    case (phase_q)
      PH_RIFF_TAG, PH_WAVE_TAG, PH_CHUNK_ID: begin
        tag_d = tag_next;
        if (fcnt_q >= 4'd3) begin
          fcnt_d = '0;
          if (phase_q == PH_RIFF_TAG) begin
            if (tag_next != TAG_RIFF) begin
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_NOT_RIFF;
              phase_d        = PH_ERROR;
            end else begin
              phase_d = PH_RIFF_SIZE;
            end
          end else if (phase_q == PH_WAVE_TAG) begin
            if (tag_next != TAG_WAVE) begin
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_NOT_WAVE;
              phase_d        = PH_ERROR;
            end else begin
              phase_d = PH_CHUNK_ID;
            end
          end else begin
            clen_d  = '0;
            phase_d = PH_CHUNK_SIZE;
          end
        end else begin
          fcnt_d = fcnt_q + 4'd1;
        end
      end
      PH_RIFF_SIZE: begin
        if (fcnt_q >= 4'd3) begin
          fcnt_d  = '0;
          phase_d = PH_WAVE_TAG;
        end else begin
          fcnt_d = fcnt_q + 4'd1;
        end
      end
      PH_CHUNK_SIZE: begin
        clen_d = clen_new;
        if (fcnt_q >= 4'd3) begin
          // Chunk header complete: dispatch on the chunk id.
          fcnt_d = '0;
          if (tag_q == TAG_FMT) begin
            if (clen_new < FMT_MIN_LEN) begin
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_FMT_SMALL;
              phase_d        = PH_ERROR;
            end else begin
              phase_d = PH_FMT_BODY;
            end
          end else if (tag_q == TAG_DATA) begin
            if (!fmt_seen_q) begin
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_FMT_MISSING;
              phase_d        = PH_ERROR;
            end else if (chan_q == '0 || width_q == '0) begin
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_ZERO_FORMAT;
              phase_d        = PH_ERROR;
            end else begin
              drem_d = clen_new;
              cur_d  = '0;
              if (clen_new < {15'd0, frame_bytes}) begin
                res_valid = 1'b1;
                res.kind  = KIND_DONE;
                phase_d   = PH_DONE;
              end else begin
                phase_d = PH_DATA;
              end
            end
          end else begin
            skip_d  = clen_new;
            phase_d = (clen_new != '0) ? PH_SKIP : PH_CHUNK_ID;
          end
        end else begin
          fcnt_d = fcnt_q + 4'd1;
        end
      end
      PH_FMT_BODY: begin
        fcnt_d = fcnt_q + 4'd1;
        case (fcnt_q)
          4'd2:  chan_d = {8'd0, s1_byte_q};
          4'd3:  chan_d = {chan_q[15:8] | s1_byte_q, chan_q[7:0]};
          4'd4:  rate_d = {24'd0, s1_byte_q};
          4'd5:  rate_d = {rate_q[31:16], rate_q[15:8] | s1_byte_q, rate_q[7:0]};
          4'd6:  rate_d = {rate_q[31:24], rate_q[23:16] | s1_byte_q, rate_q[15:0]};
          4'd7:  rate_d = {rate_q[31:24] | s1_byte_q, rate_q[23:0]};
          4'd14: low_d  = s1_byte_q;
          4'd15: begin
            fcnt_d = '0;
            if (bits > BITS_MAX) begin
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_WIDE_SAMPLE;
              phase_d        = PH_ERROR;
            end else begin
              // Bits per sample is at most 16 here, so bits [4:3] hold bits / 8.
              width_d              = bits[4:3];
              fmt_seen_d           = 1'b1;
              res_valid            = 1'b1;
              res.kind             = KIND_FORMAT;
              res.sample_rate      = rate_q;
              res.channel_count    = chan_q;
              res.bytes_per_sample = bits[4:3];
              skip_d               = clen_q - FMT_MIN_LEN;
              phase_d              = (clen_q != FMT_MIN_LEN) ? PH_SKIP : PH_CHUNK_ID;
            end
          end
          default: ;
        endcase
      end
      PH_SKIP: begin
        skip_d = skip_q - 32'd1;
        if (skip_q == 32'd1) begin
          fcnt_d  = '0;
          phase_d = PH_CHUNK_ID;
        end
      end
      PH_DATA: begin
        if (cur_q == '0 && fcnt_q == '0 && drem_q < {15'd0, frame_bytes}) begin
          res_valid = 1'b1;
          res.kind  = KIND_DONE;
          phase_d   = PH_DONE;
        end else begin
          drem_d = drem_q - 32'd1;
          if (width_q == 2'd1 || fcnt_q != '0) begin
            res_valid         = 1'b1;
            res.kind          = KIND_SAMPLE;
            res.channel_index = cur_q;
            res.sample        = (width_q == 2'd1) ? {{8{s1_byte_q[7]}}, s1_byte_q}
                                                  : {s1_byte_q, low_q};
            cur_d             = (cur_inc >= {1'b0, chan_q}) ? '0 : cur_inc[15:0];
            fcnt_d            = '0;
          end else begin
            low_d  = s1_byte_q;
            fcnt_d = 4'd1;
          end
        end
      end
      default: ;
    endcase

    if (s1_eos_q) begin
      complete = (phase_d == PH_DONE) || (phase_d == PH_ERROR) ||
                 (phase_d == PH_DATA && cur_d == '0 && fcnt_d == '0 &&
                  drem_d < {15'd0, frame_bytes});
      if (!complete) begin
        res_valid      = 1'b1;
        res            = '0;
        res.kind       = KIND_ERROR;
        res.error_code = (phase_d == PH_CHUNK_ID && fcnt_d == '0) ? ERR_NO_DATA
                                                                  : ERR_TRUNCATED;
      end
      // The stream ends here: rearm for the next file.
      phase_d    = PH_RIFF_TAG;
      fcnt_d     = '0;
      tag_d      = '0;
      clen_d     = '0;
      skip_d     = '0;
      drem_d     = '0;
      chan_d     = '0;
      rate_d     = '0;
      width_d    = '0;
      fmt_seen_d = 1'b0;
      low_d      = '0;
      cur_d      = '0;
    end
  end

  // The held byte moves on unless it has a result and the result register is full and not being read.
  assign advance    = s1_valid_q && (!res_valid || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_RIFF_TAG;
      fcnt_q      <= '0;
      tag_q       <= '0;
      clen_q      <= '0;
      skip_q      <= '0;
      drem_q      <= '0;
      chan_q      <= '0;
      rate_q      <= '0;
      width_q     <= '0;
      fmt_seen_q  <= 1'b0;
      low_q       <= '0;
      cur_q       <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        phase_q    <= phase_d;
        fcnt_q     <= fcnt_d;
        tag_q      <= tag_d;
        clen_q     <= clen_d;
        skip_q     <= skip_d;
        drem_q     <= drem_d;
        chan_q     <= chan_d;
        rate_q     <= rate_d;
        width_q    <= width_d;
        fmt_seen_q <= fmt_seen_d;
        low_q      <= low_d;
        cur_q      <= cur_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= in_byte_i;
      s1_eos_q  <= end_of_stream_i;
    end
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign kind_o             = out_q.kind;
  assign sample_o           = out_q.sample;
  assign channel_index_o    = out_q.channel_index;
  assign sample_rate_o      = out_q.sample_rate;
  assign channel_count_o    = out_q.channel_count;
  assign bytes_per_sample_o = out_q.bytes_per_sample;
  assign error_code_o       = out_q.error_code;

  `WSP_ASSERT_IMP(a_data_format_valid, clk_i, rst_ni, phase_q == PH_DATA,
    width_q != 2'd0 && chan_q != 16'd0 && cur_q < chan_q,
    "Data phase with invalid format or channel")
  `WSP_ASSERT_IMP(a_data_byte_count, clk_i, rst_ni, phase_q == PH_DATA,
    fcnt_q <= 4'd1, "Data phase byte count out of range")
  `WSP_ASSERT_NEXT(a_error_sticks, clk_i, rst_ni,
    advance && res_valid && res.kind == KIND_ERROR,
    phase_q == PH_ERROR || phase_q == PH_RIFF_TAG,
    "Error result without error phase or rearm")
  `WSP_ASSERT_NEXT(a_eos_rearms, clk_i, rst_ni, advance && s1_eos_q,
    phase_q == PH_RIFF_TAG && fmt_seen_q == 1'b0,
    "Parser did not rearm after end of stream")
  `WSP_ASSERT_NEVER(a_format_width, clk_i, rst_ni,
    out_valid_q && out_q.kind == KIND_FORMAT && out_q.bytes_per_sample == 2'd3,
    "Format result with impossible sample width")

endmodule
